// ===== rtl/core/bjq_pkg.sv =====
// ----------------------------------------------------------------------------
// bjq_pkg
// Shared types, codes and widths of the bounded job queue with admission.
// ----------------------------------------------------------------------------
package bjq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int CNT_W    = 5;
  localparam int ID_W     = 32;
  localparam int HANDLE_W = 16;
  localparam int CLIENT_W = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_PAY_W   = ID_W + HANDLE_W + CLIENT_W + 2 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CNT_W-1:0] CAPACITY_RST    = 5'd16;
  localparam logic [CNT_W-1:0] CONCURRENCY_RST = 5'd1;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONCURRENCY = 1'd1;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_START   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;
  localparam logic [OP_W-1:0] OP_FINISH  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONERUN  = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [CLIENT_W-1:0] client;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                req_load;
    logic                enq_commit;
    logic                fin_commit;
    logic                refuse;
    logic [STATUS_W-1:0] refuse_code;
    logic                ptr_clear;
    logic                ptr_inc;
    logic                rd_en;
    logic                rd_next;
    logic                capture;
    logic                shift_wr;
    logic                remove;
    logic                out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            limit;
    logic            none_run;
    logic            id_match;
    logic            more;
    logic            more2;
    logic            out_free;
  } sts_t;

endpackage

// ===== rtl/core/bjq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bjq_ctrl
// Sequencer for the job queue: decides each operation, walks the entry
// memory for search and compaction, and hands the result to the output.
// ----------------------------------------------------------------------------
module bjq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  bjq_pkg::sts_t sts,
  output bjq_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SRD    = 3'd2;
  localparam logic [2:0] S_SCMP   = 3'd3;
  localparam logic [2:0] S_HRD    = 3'd4;
  localparam logic [2:0] S_HWR    = 3'd5;
  localparam logic [2:0] S_REMOVE = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        unique case (sts.op)
          bjq_pkg::OP_ENQUEUE: begin
            if (sts.full) begin
              cmd.refuse      = 1'b1;
              cmd.refuse_code = bjq_pkg::ST_FULL;
            end else begin
              cmd.enq_commit = 1'b1;
            end
          end
          bjq_pkg::OP_START: begin
            if (sts.empty) begin
              cmd.refuse      = 1'b1;
              cmd.refuse_code = bjq_pkg::ST_EMPTY;
            end else if (sts.limit) begin
              cmd.refuse      = 1'b1;
              cmd.refuse_code = bjq_pkg::ST_LIMIT;
            end else begin
              cmd.ptr_clear = 1'b1;
              state_nxt     = S_SRD;
            end
          end
          bjq_pkg::OP_DELETE: begin
            if (sts.empty) begin
              cmd.refuse      = 1'b1;
              cmd.refuse_code = bjq_pkg::ST_NOTFOUND;
            end else begin
              cmd.ptr_clear = 1'b1;
              state_nxt     = S_SRD;
            end
          end
          bjq_pkg::OP_FINISH: begin
            if (sts.none_run) begin
              cmd.refuse      = 1'b1;
              cmd.refuse_code = bjq_pkg::ST_NONERUN;
            end else begin
              cmd.fin_commit = 1'b1;
            end
          end
        endcase
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        // Start always takes the head entry, which is the first one read.
        if (sts.op == bjq_pkg::OP_START || sts.id_match) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.more ? S_HRD : S_REMOVE;
        end else if (sts.more) begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SRD;
        end else begin
          cmd.refuse      = 1'b1;
          cmd.refuse_code = bjq_pkg::ST_NOTFOUND;
          state_nxt       = S_DONE;
        end
      end
      S_HRD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_next = 1'b1;
        state_nxt   = S_HWR;
      end
      S_HWR: begin
        cmd.shift_wr = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_nxt    = sts.more2 ? S_HRD : S_REMOVE;
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.req_load |=> state_r == S_DECIDE)
    else $error("accepted word did not reach the decide step");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_tready)
    else $error("controller not idle after handing off a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> $past(cmd.rd_en) && $past(cmd.rd_next))
    else $error("compaction write without a preceding read of the next entry");

endmodule

// ===== rtl/core/bjq_dpath.sv =====
// ----------------------------------------------------------------------------
// bjq_dpath
// Entry memory, counters, configuration registers, request latch, result
// staging and the output register of the job queue.
// ----------------------------------------------------------------------------
module bjq_dpath #(
  parameter int DEPTH = bjq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bjq_pkg::cmd_t                     cmd,
  output bjq_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [bjq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bjq_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic [bjq_pkg::OP_W-1:0]          in_opcode,
  input  logic [bjq_pkg::HANDLE_W-1:0]      in_handle,
  input  logic [bjq_pkg::CLIENT_W-1:0]      in_client,
  input  logic [bjq_pkg::ID_W-1:0]          in_target,
  input  logic                              out_tready,
  output logic                              out_valid,
  output logic [bjq_pkg::STATUS_W-1:0]      out_status,
  output logic [bjq_pkg::ID_W-1:0]          out_id,
  output logic [bjq_pkg::HANDLE_W-1:0]      out_handle,
  output logic [bjq_pkg::CLIENT_W-1:0]      out_client,
  output logic [bjq_pkg::CNT_W-1:0]         out_queued,
  output logic [bjq_pkg::CNT_W-1:0]         out_running
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > bjq_pkg::CNT_W) ? CW : bjq_pkg::CNT_W;

  // Entry memory, index 0 the oldest waiting job.
  bjq_pkg::entry_t mem [DEPTH];
  bjq_pkg::entry_t rd_data_r;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  bjq_pkg::entry_t wr_data;
  bjq_pkg::entry_t enq_data;
  logic [AW-1:0]   rd_addr;

  logic [CW-1:0]               wc_r;
  logic [bjq_pkg::ID_W-1:0]    next_id_r;
  logic [bjq_pkg::CNT_W-1:0]   run_r;
  logic [bjq_pkg::CNT_W-1:0]   cap_r;
  logic [bjq_pkg::CNT_W-1:0]   conc_r;
  logic [AW-1:0]               ptr_r;
  logic                        out_valid_r;

  logic [bjq_pkg::OP_W-1:0]     op_r;
  logic [bjq_pkg::HANDLE_W-1:0] handle_r;
  logic [bjq_pkg::CLIENT_W-1:0] client_r;
  logic [bjq_pkg::ID_W-1:0]     target_r;

  logic [bjq_pkg::STATUS_W-1:0] res_status_r;
  bjq_pkg::entry_t              res_r;

  logic [bjq_pkg::STATUS_W-1:0] out_status_r;
  bjq_pkg::entry_t              out_r;
  logic [bjq_pkg::CNT_W-1:0]    out_queued_r;
  logic [bjq_pkg::CNT_W-1:0]    out_running_r;

  logic [CMPW-1:0] wc_ext;
  logic [CW:0]     ptr_p1;
  logic [CW:0]     ptr_p2;
  logic [CW:0]     wc_w;
  logic [AW-1:0]   ptr_inc;

  assign wc_ext  = CMPW'(wc_r);
  assign ptr_p1  = (CW + 1)'(ptr_r) + (CW + 1)'(1);
  assign ptr_p2  = (CW + 1)'(ptr_r) + (CW + 1)'(2);
  assign wc_w    = (CW + 1)'(wc_r);
  assign ptr_inc = ptr_r + AW'(1);

  // The capacity limit saturates at the memory depth.
  assign sts.op       = op_r;
  assign sts.full     = (wc_ext >= CMPW'(cap_r)) || (wc_r == CW'(DEPTH));
  assign sts.empty    = (wc_r == '0);
  assign sts.limit    = (run_r >= conc_r);
  assign sts.none_run = (run_r == '0);
  assign sts.id_match = (rd_data_r.id == target_r);
  assign sts.more     = (ptr_p1 < wc_w);
  assign sts.more2    = (ptr_p2 < wc_w);
  assign sts.out_free = !out_valid_r || out_tready;

  assign enq_data = '{id: next_id_r, handle: handle_r, client: client_r};
  assign wr_en    = cmd.enq_commit || cmd.shift_wr;
  assign wr_addr  = cmd.shift_wr ? ptr_r : wc_r[AW-1:0];
  assign wr_data  = cmd.shift_wr ? rd_data_r : enq_data;
  assign rd_addr  = cmd.rd_next ? ptr_inc : ptr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r        <= '0;
      next_id_r   <= '0;
      run_r       <= '0;
      cap_r       <= bjq_pkg::CAPACITY_RST;
      conc_r      <= bjq_pkg::CONCURRENCY_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bjq_pkg::REG_CAPACITY:    cap_r  <= cfg_wdata;
          bjq_pkg::REG_CONCURRENCY: conc_r <= cfg_wdata;
        endcase
      end
      if (cmd.enq_commit) begin
        wc_r      <= wc_r + CW'(1);
        next_id_r <= next_id_r + bjq_pkg::ID_W'(1);
      end
      if (cmd.remove) begin
        wc_r <= wc_r - CW'(1);
        if (op_r == bjq_pkg::OP_START) begin
          run_r <= run_r + bjq_pkg::CNT_W'(1);
        end
      end
      if (cmd.fin_commit) begin
        run_r <= run_r - bjq_pkg::CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      op_r     <= in_opcode;
      handle_r <= in_handle;
      client_r <= in_client;
      target_r <= in_target;
    end
    if (cmd.ptr_clear) begin
      ptr_r <= '0;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_inc;
    end
    if (cmd.refuse) begin
      res_status_r <= cmd.refuse_code;
      res_r        <= '0;
    end else if (cmd.enq_commit) begin
      res_status_r <= bjq_pkg::ST_OK;
      res_r        <= '{id: next_id_r, handle: '0, client: '0};
    end else if (cmd.fin_commit) begin
      res_status_r <= bjq_pkg::ST_OK;
      res_r        <= '0;
    end else if (cmd.capture) begin
      res_status_r <= bjq_pkg::ST_OK;
      res_r        <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_status_r  <= res_status_r;
      out_r         <= res_r;
      out_queued_r  <= wc_ext[bjq_pkg::CNT_W-1:0];
      out_running_r <= run_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_id      = out_r.id;
  assign out_handle  = out_r.handle;
  assign out_client  = out_r.client;
  assign out_queued  = out_queued_r;
  assign out_running = out_running_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_commit |-> !sts.full && wc_r < CW'(DEPTH))
    else $error("enqueue written past the admission limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |-> wc_r != '0)
    else $error("entry removed from an empty queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> sts.more)
    else $error("compaction write beyond the waiting entries");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove && op_r == bjq_pkg::OP_START |-> run_r < conc_r)
    else $error("job started above the concurrency limit");

endmodule

// ===== rtl/core/bounded_job_queue_with_admission_top.sv =====
// ----------------------------------------------------------------------------
// bounded_job_queue_with_admission_top
// Ordered job queue with capacity and concurrency admission, delete by id.
//
//   channel  dir  handshake           tdata / tuser
//   in_      in   in_tvalid/tready    job_handle, client_id, target_id / opcode
//   out_     out  out_tvalid/tready   job_id, handles, counts / status
//   cfg_     in   cfg_we              capacity, concurrency by cfg_index
//
// Enqueue, finish and the refusals decided at once pass the accept, decide
// and done states; done waits while the output word is not yet taken. Start and
// delete walk the entry memory: a read and a compare per entry compared, a
// read and a write per entry shifted down, then a remove. One word is in
// work at a time; the next is accepted once the result enters the output
// register, even while that word waits. Reset is synchronous; no memory clear.
// ----------------------------------------------------------------------------
module bounded_job_queue_with_admission_top #(
  parameter int DEPTH = bjq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bjq_pkg::IN_TDATA_W-1:0]     in_tdata,   // job_handle, client_id, target_id
  input  logic [bjq_pkg::OP_W-1:0]           in_tuser,   // opcode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // job_id, job_handle_out, client_id_out, queued_count, running_count, zero pad
  output logic [bjq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [bjq_pkg::STATUS_W-1:0]       out_tuser,  // status
  input  logic                               cfg_we,
  input  logic [bjq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bjq_pkg::CNT_W-1:0]          cfg_wdata
);

  bjq_pkg::cmd_t cmd;
  bjq_pkg::sts_t sts;

  logic [bjq_pkg::ID_W-1:0]     out_id;
  logic [bjq_pkg::HANDLE_W-1:0] out_handle;
  logic [bjq_pkg::CLIENT_W-1:0] out_client;
  logic [bjq_pkg::CNT_W-1:0]    out_queued;
  logic [bjq_pkg::CNT_W-1:0]    out_running;

  bjq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bjq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_opcode   (in_tuser),
    .in_handle   (in_tdata[15:0]),
    .in_client   (in_tdata[31:16]),
    .in_target   (in_tdata[63:32]),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_status  (out_tuser),
    .out_id      (out_id),
    .out_handle  (out_handle),
    .out_client  (out_client),
    .out_queued  (out_queued),
    .out_running (out_running)
  );

  assign out_tdata = {{(bjq_pkg::OUT_TDATA_W - bjq_pkg::OUT_PAY_W){1'b0}},
                      out_running, out_queued, out_client, out_handle, out_id};

endmodule

// ===== bench/bjq_checker.sv =====
// ----------------------------------------------------------------------------
// bjq_checker
// Watches the command and result channels of the bounded job queue. It keeps
// its own copy of the queue, the id counter, the running count and both
// admission registers, and predicts one result word per accepted command.
// Each accepted result word is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module bjq_checker #(
  parameter int DEPTH = bjq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bjq_pkg::IN_TDATA_W-1:0]  in_tdata,   // job_handle, client_id, target_id
  input  logic [bjq_pkg::OP_W-1:0]        in_tuser,   // opcode
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // job_id, job_handle_out, client_id_out, queued_count, running_count, zero pad
  input  logic [bjq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [bjq_pkg::STATUS_W-1:0]    out_tuser,  // status
  input  logic                            cfg_we,
  input  logic [bjq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bjq_pkg::CNT_W-1:0]       cfg_wdata,
  output int                              fail_count,
  output int                              pending,
  output logic [bjq_pkg::ID_W-1:0]        id_hint
);
  import bjq_pkg::*;

  localparam int HANDLE_LSB  = ID_W;
  localparam int CLIENT_LSB  = ID_W + HANDLE_W;
  localparam int QUEUED_LSB  = ID_W + HANDLE_W + CLIENT_W;
  localparam int RUNNING_LSB = QUEUED_LSB + CNT_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     job_id;
    logic [HANDLE_W-1:0] handle;
    logic [CLIENT_W-1:0] client;
    logic [CNT_W-1:0]    queued;
    logic [CNT_W-1:0]    running;
  } job_result_t;

  // Waiting jobs, index 0 the oldest.
  logic [ID_W-1:0]     job_ids     [DEPTH];
  logic [HANDLE_W-1:0] job_handles [DEPTH];
  logic [CLIENT_W-1:0] job_clients [DEPTH];
  int                  waiting;
  int                  running_jobs;
  logic [ID_W-1:0]     id_counter;
  logic [CNT_W-1:0]    capacity_reg;
  logic [CNT_W-1:0]    concurrency_reg;

  job_result_t due_results[$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string text);
    if (mismatches < 100) $display("mismatch: %s (t=%0t)", text, $time);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [ID_W-1:0] got,
                               input logic [ID_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Closes the gap left by the job at pos.
  task automatic drop_job(input int pos);
    for (int i = pos; i + 1 < waiting; i++) begin
      job_ids[i]     = job_ids[i + 1];
      job_handles[i] = job_handles[i + 1];
      job_clients[i] = job_clients[i + 1];
    end
    waiting--;
  endtask

  task automatic run_command(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
                             input logic [CLIENT_W-1:0] client,
                             input logic [ID_W-1:0] target, output job_result_t r);
    int limit;
    int pos;
    limit = (capacity_reg < DEPTH) ? int'(capacity_reg) : DEPTH;
    pos = -1;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ENQUEUE: begin
        if (waiting >= limit) begin
          r.status = ST_FULL;
        end else begin
          job_ids[waiting]     = id_counter;
          job_handles[waiting] = handle;
          job_clients[waiting] = client;
          waiting++;
          r.job_id = id_counter;
          id_counter++;
        end
      end
      OP_START: begin
        if (waiting == 0) begin
          r.status = ST_EMPTY;
        end else if (running_jobs >= int'(concurrency_reg)) begin
          r.status = ST_LIMIT;
        end else begin
          r.job_id = job_ids[0];
          r.handle = job_handles[0];
          r.client = job_clients[0];
          drop_job(0);
          running_jobs++;
        end
      end
      OP_DELETE: begin
        for (int i = 0; i < waiting; i++)
          if (pos < 0 && job_ids[i] == target) pos = i;
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.job_id = job_ids[pos];
          r.handle = job_handles[pos];
          r.client = job_clients[pos];
          drop_job(pos);
        end
      end
      default: begin
        if (running_jobs == 0) r.status = ST_NONERUN;
        else running_jobs--;
      end
    endcase
    r.queued  = waiting[CNT_W-1:0];
    r.running = running_jobs[CNT_W-1:0];
  endtask

  always @(posedge clk) begin
    job_result_t want;
    job_result_t got;
    if (!rst_n) begin
      waiting         = 0;
      running_jobs    = 0;
      id_counter      = '0;
      capacity_reg    = CAPACITY_RST;
      concurrency_reg = CONCURRENCY_RST;
      due_results.delete();
    end else begin
      // A result word leaves before the command taken at the same edge is predicted.
      if (out_tvalid && out_tready) begin
        got.status  = out_tuser;
        got.job_id  = out_tdata[0 +: ID_W];
        got.handle  = out_tdata[HANDLE_LSB +: HANDLE_W];
        got.client  = out_tdata[CLIENT_LSB +: CLIENT_W];
        got.queued  = out_tdata[QUEUED_LSB +: CNT_W];
        got.running = out_tdata[RUNNING_LSB +: CNT_W];
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result word 0x%0h with nothing expected", out_tdata));
        end else begin
          want = due_results.pop_front();
          compare_field("status", got.status, want.status);
          compare_field("job_id", got.job_id, want.job_id);
          compare_field("job_handle_out", got.handle, want.handle);
          compare_field("client_id_out", got.client, want.client);
          compare_field("queued_count", got.queued, want.queued);
          compare_field("running_count", got.running, want.running);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) capacity_reg = cfg_wdata;
        else if (cfg_index == REG_CONCURRENCY) concurrency_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        run_command(in_tuser, in_tdata[0 +: HANDLE_W], in_tdata[HANDLE_W +: CLIENT_W],
                    in_tdata[HANDLE_W + CLIENT_W +: ID_W], want);
        due_results.push_back(want);
      end
    end
    pending <= due_results.size();
    id_hint <= id_counter;
  end

endmodule

// ===== bench/bounded_job_queue_with_admission_top_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_job_queue_with_admission_top_tb
// Drives job commands into the queue: a directed opening that hits refusals,
// middle and oldest deletes and zero limits, then random fill and drain
// traffic under several capacity and concurrency settings. Both channels
// stall at random. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module bounded_job_queue_with_admission_top_tb;
  import bjq_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // job_handle, client_id, target_id
  logic [OP_W-1:0]        in_tuser;   // opcode
  logic                   out_tvalid;
  logic                   out_tready;
  // job_id, job_handle_out, client_id_out, queued_count, running_count, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;  // status
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CNT_W-1:0]       cfg_wdata;

  int              fail_count;
  int              pending;
  logic [ID_W-1:0] id_hint;

  // While calm is set neither side idles.
  logic calm;
  logic filling;
  int   calm_left = 0;
  int   fill_left = 0;
  int   stall_left = 0;
  int   stall_draw;

  bounded_job_queue_with_admission_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  bjq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .id_hint    (id_hint)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: after each word taken, hold ready low for a random stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      stall_draw = calm ? 0 : $urandom_range(0, 11);
      stall_left <= stall_draw;
      out_tready <= (stall_draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Valid stays high across back-to-back words; it drops only for a gap, a register write or the end of the run.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
                           input logic [CLIENT_W-1:0] client, input logic [ID_W-1:0] target);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {target, client, handle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Registers change only once every predicted result has come back.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CNT_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_command();
    int              roll;
    int              pick;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] target;
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(10, 40);
    end else begin
      calm_left--;
    end
    if (fill_left == 0) begin
      filling <= !filling;
      fill_left = $urandom_range(8, 24);
    end else begin
      fill_left--;
    end
    roll = $urandom_range(0, 99);
    if (filling)
      op = (roll < 55) ? OP_ENQUEUE : (roll < 70) ? OP_START :
           (roll < 85) ? OP_DELETE : OP_FINISH;
    else
      op = (roll < 15) ? OP_ENQUEUE : (roll < 50) ? OP_START :
           (roll < 80) ? OP_DELETE : OP_FINISH;
    // Most deletes aim at recently issued ids so that they hit live jobs.
    pick = $urandom_range(0, 9);
    if (pick < 7) target = id_hint - $urandom_range(1, 18);
    else if (pick < 9) target = $urandom;
    else target = id_hint;
    send_word(op, HANDLE_W'($urandom), CLIENT_W'($urandom), target);
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] capacity, input logic [CNT_W-1:0] concurrency,
                           input int words);
    write_register(REG_CAPACITY, capacity);
    write_register(REG_CONCURRENCY, concurrency);
    repeat (words) random_command();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_ENQUEUE;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_CAPACITY;
    cfg_wdata  <= '0;
    calm       <= 1'b0;
    filling    <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: room for sixteen, one job at a time.
    send_word(OP_FINISH, 16'h0000, 16'h0000, 32'h0000_0000);
    send_word(OP_START, 16'h0000, 16'h0000, 32'h0000_0000);
    send_word(OP_DELETE, 16'h0000, 16'h0000, 32'h0000_0000);
    send_word(OP_ENQUEUE, 16'hffff, 16'h0000, 32'hffff_ffff);
    send_word(OP_ENQUEUE, 16'h0000, 16'hffff, 32'h0000_0000);
    send_word(OP_ENQUEUE, 16'ha5a5, 16'h5a5a, 32'h0000_0000);
    send_word(OP_DELETE, 16'h0000, 16'h0000, 32'h0000_0001);
    send_word(OP_DELETE, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_word(OP_START, 16'h0000, 16'h0000, 32'h0000_0000);
    send_word(OP_ENQUEUE, 16'h1234, 16'hfedc, 32'h0000_0000);
    send_word(OP_DELETE, 16'h0000, 16'h0000, 32'h0000_0002);
    send_word(OP_START, 16'h0000, 16'h0000, 32'h0000_0000);
    send_word(OP_FINISH, 16'hffff, 16'hffff, 32'hffff_ffff);

    // Both limits at zero: nothing may be added or started.
    write_register(REG_CAPACITY, 5'd0);
    write_register(REG_CONCURRENCY, 5'd0);
    send_word(OP_ENQUEUE, 16'h0f0f, 16'hf0f0, 32'h0000_0000);
    send_word(OP_START, 16'h0000, 16'h0000, 32'h0000_0000);
    send_word(OP_DELETE, 16'h0000, 16'h0000, 32'h0000_0003);
    send_word(OP_START, 16'h0000, 16'h0000, 32'h0000_0000);

    run_phase(5'd31, 5'd16, 80);
    run_phase(5'd4, 5'd2, 80);
    run_phase(5'd1, 5'd1, 50);
    run_phase(5'd16, 5'd31, 80);
    run_phase(5'd0, 5'd3, 30);
    run_phase(5'd9, 5'd0, 60);
    run_phase(5'd16, 5'd4, 80);
    run_phase(5'd31, 5'd1, 50);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bjq_pkg.sv
rtl/core/bjq_ctrl.sv
rtl/core/bjq_dpath.sv
rtl/core/bounded_job_queue_with_admission_top.sv
bench/bjq_checker.sv
bench/bounded_job_queue_with_admission_top_tb.sv
